// File: rtl/bpcd_pkg.sv
// Shared types and constants for the brush pressure curve dab parameter block.
// Used by every module under rtl/ but bpcd_curve_mem; depends on nothing.
`timescale 1ns / 1ps
package bpcd_pkg;

  localparam int CHANNELS = 4;

  // Request types.
  localparam logic REQ_EVAL = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  // Channel numbers, also the bit positions in pressure_enables.
  localparam int CH_SIZE     = 0;
  localparam int CH_HARDNESS = 1;
  localparam int CH_OPACITY  = 2;
  localparam int CH_SMUDGE   = 3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SIZE_RANGE       = 3'd0;
  localparam logic [2:0] CFG_HARDNESS_RANGE   = 3'd1;
  localparam logic [2:0] CFG_OPACITY_RANGE    = 3'd2;
  localparam logic [2:0] CFG_SMUDGE_RANGE     = 3'd3;
  localparam logic [2:0] CFG_SPACING_FACTOR   = 3'd4;
  localparam logic [2:0] CFG_PRESSURE_ENABLES = 3'd5;

  // Register reset values.
  localparam logic [31:0] SIZE_RANGE_RESET   = 32'h0100_0000;
  localparam logic [31:0] UNIT_RANGE_RESET   = 32'hFFFF_0000;
  localparam logic [15:0] SPACING_RESET      = 16'h1000;
  localparam logic [3:0]  ENABLES_RESET      = 4'h0;

  localparam logic [16:0] PRESSURE_ONE = 17'h10000;

  typedef struct packed {
    logic        req_type;
    logic [1:0]  curve_channel;
    logic [7:0]  curve_slot;
    logic [15:0] curve_value;
    logic [16:0] pressure;
  } req_t;

  typedef struct packed {
    logic [15:0] soft_dab_size;
    logic [7:0]  pixel_dab_size;
    logic [7:0]  dab_opacity;
    logic [7:0]  dab_hardness;
    logic [15:0] smudge_amount;
    logic [19:0] spacing_distance;
  } dab_t;

  // Advance strobes for the two per-channel stages.
  typedef struct packed {
    logic s3;
    logic s4;
  } lane_adv_t;

endpackage

// File: rtl/brush_pressure_curve_dab_params.sv
// Brush dab parameters from pen pressure, top level: configuration, pipeline control,
// curve tables. Depends on bpcd_pkg, bpcd_curve_mem, bpcd_lane and bpcd_format.
`timescale 1ns / 1ps

// Takes one request per clock unless back-pressure holds it; each evaluate request
// returns one dab beat after pressure index multiply, curve table read, interpolation
// multiply, range scaling multiply, output rounding with the spacing multiply. Each
// of the four channels has its own curve table with two read ports, so all four curves
// are looked up in the same cycle. A load request takes one slot, writes its entry at
// the table stage and gives no beat; a later evaluate always sees it. Every stage holds
// under back-pressure and bubbles are squeezed out, so the sustained rate is one request
// per cycle while the dab side takes a beat per cycle. The curve tables have no reset;
// configuration registers should be written only while no request is in flight.
module brush_pressure_curve_dab_params
  import bpcd_pkg::*;
#(
  parameter int CURVE_POINTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        dab_valid,
  input  logic        dab_ready,
  output dab_t        dab,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IDX_W = (CURVE_POINTS > 1) ? $clog2(CURVE_POINTS) : 1;
  localparam int PROD_W = IDX_W + 17;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(CURVE_POINTS - 1);

  // Configuration registers.
  logic [31:0] size_range;
  logic [31:0] hardness_range;
  logic [31:0] opacity_range;
  logic [31:0] smudge_range;
  logic [15:0] spacing_factor;
  logic [3:0]  pressure_enables;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_range       <= SIZE_RANGE_RESET;
      hardness_range   <= UNIT_RANGE_RESET;
      opacity_range    <= UNIT_RANGE_RESET;
      smudge_range     <= UNIT_RANGE_RESET;
      spacing_factor   <= SPACING_RESET;
      pressure_enables <= ENABLES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SIZE_RANGE:       size_range       <= cfg_data;
        CFG_HARDNESS_RANGE:   hardness_range   <= cfg_data;
        CFG_OPACITY_RANGE:    opacity_range    <= cfg_data;
        CFG_SMUDGE_RANGE:     smudge_range     <= cfg_data;
        CFG_SPACING_FACTOR:   spacing_factor   <= cfg_data[15:0];
        CFG_PRESSURE_ENABLES: pressure_enables <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Pipeline valids and ready chain.
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic ready2, ready3, ready4, ready5;

  assign ready5    = !dab_valid || dab_ready;
  assign ready4    = !s4_valid || ready5;
  assign ready3    = !s3_valid || ready4;
  assign ready2    = !s2_valid || ready3;
  assign req_ready = !s1_valid || ready2;

  // Stage 1: saturate pressure and split p*(N-1) into entry index and fraction.
  logic [16:0]       p_sat;
  logic [PROD_W-1:0] t_prod;
  logic              slot_ok;

  always_comb begin
    p_sat   = (req.pressure > PRESSURE_ONE) ? PRESSURE_ONE : req.pressure;
    t_prod  = PROD_W'(p_sat) * PROD_W'(LAST);
    slot_ok = 32'(req.curve_slot) < 32'(CURVE_POINTS);
  end

  logic             s1_load;
  logic [1:0]       s1_ch;
  logic [IDX_W-1:0] s1_slot;
  logic [15:0]      s1_value;
  logic [IDX_W-1:0] s1_idx;
  logic [15:0]      s1_frac;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid && (req.req_type == REQ_EVAL || slot_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready) begin
      s1_load  <= (req.req_type == REQ_LOAD);
      s1_ch    <= req.curve_channel;
      s1_slot  <= IDX_W'(req.curve_slot);
      s1_value <= req.curve_value;
      s1_idx   <= t_prod[IDX_W+15:16];
      s1_frac  <= t_prod[15:0];
    end
  end

  // Stage 2: curve tables. Loads write here and leave the pipeline.
  logic [IDX_W-1:0] addr_b;
  logic [15:0]      entry_a [CHANNELS];
  logic [15:0]      entry_b [CHANNELS];
  logic [15:0]      s2_frac;

  // At the top entry the fraction is zero, so the clamped second address does not matter.
  assign addr_b = (s1_idx == LAST) ? LAST : s1_idx + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (ready2) begin
      s2_valid <= s1_valid && !s1_load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      s2_frac <= s1_frac;
    end
  end

  logic [31:0] ch_range [CHANNELS];
  logic [15:0] ch_value [CHANNELS];
  lane_adv_t   lane_adv;

  assign ch_range[CH_SIZE]     = size_range;
  assign ch_range[CH_HARDNESS] = hardness_range;
  assign ch_range[CH_OPACITY]  = opacity_range;
  assign ch_range[CH_SMUDGE]   = smudge_range;

  assign lane_adv.s3 = ready3;
  assign lane_adv.s4 = ready4;

  for (genvar gi = 0; gi < CHANNELS; gi++) begin : g_ch
    bpcd_curve_mem #(
      .DEPTH (CURVE_POINTS)
    ) u_mem (
      .clk     (clk),
      .we      (ready2 && s1_valid && s1_load && s1_ch == 2'(gi)),
      .waddr   (s1_slot),
      .wdata   (s1_value),
      .re      (ready2 && s1_valid && !s1_load),
      .raddr_a (s1_idx),
      .raddr_b (addr_b),
      .rdata_a (entry_a[gi]),
      .rdata_b (entry_b[gi])
    );

    // Stages 3 and 4 live in the lane.
    bpcd_lane u_lane (
      .clk     (clk),
      .adv     (lane_adv),
      .entry_a (entry_a[gi]),
      .entry_b (entry_b[gi]),
      .frac    (s2_frac),
      .range   (ch_range[gi]),
      .follow  (pressure_enables[gi]),
      .value   (ch_value[gi])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      dab_valid <= 1'b0;
    end else begin
      if (ready3) begin
        s3_valid <= s2_valid;
      end
      if (ready4) begin
        s4_valid <= s3_valid;
      end
      if (ready5) begin
        dab_valid <= s4_valid;
      end
    end
  end

  // Stage 5: output register.
  bpcd_format u_format (
    .clk            (clk),
    .adv            (ready5),
    .size           (ch_value[CH_SIZE]),
    .hardness       (ch_value[CH_HARDNESS]),
    .opacity        (ch_value[CH_OPACITY]),
    .smudge         (ch_value[CH_SMUDGE]),
    .spacing_factor (spacing_factor),
    .dab            (dab)
  );

  // A load retires at the table stage and never reaches the arithmetic stages.
  a_load_retires: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_load && ready2) |=> !s2_valid)
    else $error("load request passed the curve table stage");

  // The entry index never runs past the top entry.
  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> s1_idx <= LAST)
    else $error("curve index beyond the last entry");

  // With an empty output register the pipeline must be open to a new request.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !dab_valid |-> req_ready)
    else $error("request side stalled with an empty output register");

  // Pixel size is clamped to at least one.
  a_pixel_nonzero: assert property (@(posedge clk) disable iff (rst)
    dab_valid |-> dab.pixel_dab_size != 8'd0)
    else $error("pixel dab size is zero");

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !dab_valid)
    else $error("dab beat valid right after reset");

endmodule

// File: rtl/bpcd_curve_mem.sv
// One channel's curve table: one write port and two registered read ports.
// Depends on nothing beyond its parameter.
`timescale 1ns / 1ps
module bpcd_curve_mem #(
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [15:0]   rdata_a,
  output logic [15:0]   rdata_b
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: rtl/bpcd_lane.sv
// One channel: interpolation between two curve entries, then scaling into min..max.
// Two register stages; uses bpcd_pkg for the advance strobe struct.
`timescale 1ns / 1ps
module bpcd_lane
  import bpcd_pkg::*;
(
  input  logic        clk,
  input  lane_adv_t   adv,
  input  logic [15:0] entry_a,
  input  logic [15:0] entry_b,
  input  logic [15:0] frac,
  input  logic [31:0] range,
  input  logic        follow,
  output logic [15:0] value
);

  logic signed [16:0] diff;
  logic signed [33:0] prod;
  logic signed [33:0] acc;
  logic [15:0]        curve;

  logic [15:0] lo;
  logic [15:0] hi;
  logic [15:0] span;
  logic [31:0] scaled;
  logic [32:0] scaled_rnd;
  logic [15:0] value_next;

  // a*(1-k) + b*k is a + (b-a)*k; the sum is rounded to nearest before bits 31:16 are taken.
  always_comb begin
    diff = $signed({1'b0, entry_b}) - $signed({1'b0, entry_a});
    prod = diff * $signed({1'b0, frac});
    acc  = $signed({2'b00, entry_a, 16'h0000}) + prod + 34'sd32768;
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      curve <= acc[31:16];
    end
  end

  always_comb begin
    lo         = range[15:0];
    hi         = range[31:16];
    span       = hi - lo;
    scaled     = span * curve;
    scaled_rnd = {1'b0, scaled} + 33'd32768;
    if (!follow || lo >= hi) begin
      value_next = hi;
    end else begin
      value_next = lo + scaled_rnd[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      value <= value_next;
    end
  end

endmodule

// File: rtl/bpcd_format.sv
// Output stage: rounds and clamps the channel values into the dab fields.
// Uses bpcd_pkg for the dab_t result type.
`timescale 1ns / 1ps
module bpcd_format
  import bpcd_pkg::*;
(
  input  logic        clk,
  input  logic        adv,
  input  logic [15:0] size,
  input  logic [15:0] hardness,
  input  logic [15:0] opacity,
  input  logic [15:0] smudge,
  input  logic [15:0] spacing_factor,
  output dab_t        dab
);

  logic [16:0] px_rnd;
  logic [7:0]  px;
  logic [31:0] spacing_prod;
  logic [32:0] spacing_rnd;
  dab_t        dab_next;

  function automatic logic [7:0] to_byte(input logic [15:0] v);
    logic [24:0] r;
    r = ({1'b0, v, 8'h00} - {9'h000, v}) + 25'd32768;
    to_byte = (r[24:16] > 9'd255) ? 8'd255 : r[23:16];
  endfunction

  always_comb begin
    px_rnd = {1'b0, size} + 17'd128;
    if (px_rnd[16]) begin
      px = 8'd255;
    end else if (px_rnd[15:8] == 8'd0) begin
      px = 8'd1;
    end else begin
      px = px_rnd[15:8];
    end
    spacing_prod = spacing_factor * size;
    spacing_rnd  = {1'b0, spacing_prod} + 33'd2048;

    dab_next.soft_dab_size    = size;
    dab_next.pixel_dab_size   = px;
    dab_next.dab_opacity      = to_byte(opacity);
    dab_next.dab_hardness     = to_byte(hardness);
    dab_next.smudge_amount    = smudge;
    dab_next.spacing_distance = spacing_rnd[31:12];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dab <= dab_next;
    end
  end

endmodule
